// File: rtl/core/fsvs_pkg.sv
// ----------------------------------------------------------------------------
// fsvs_pkg
// Shared types and constants of the focus-of-expansion sign vote search.
// ----------------------------------------------------------------------------
package fsvs_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W = 12;
    localparam int STEP_W  = 8;
    localparam int BOUND_W = 13;
    localparam int CAND_W  = BOUND_W + 1;
    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_GRID_STEP    = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [STEP_W-1:0]  GRID_STEP_RST    = 8'd16;
    localparam logic [BOUND_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [BOUND_W-1:0] IMAGE_HEIGHT_RST = 13'd480;
    localparam logic [COORD_W-1:0] COORD_MAX        = 12'hFFF;

    typedef struct packed {
        logic               has_point;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               flow_x_nonneg;
        logic               flow_y_nonneg;
        logic               last_point;
    } t_item;

    typedef struct packed {
        logic [COORD_W-1:0] foe_x;
        logic [COORD_W-1:0] foe_y;
        logic               found;
    } t_result;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               sx;
        logic               sy;
    } t_entry;

endpackage

// File: rtl/core/foe_sign_vote_search.sv
// ----------------------------------------------------------------------------
// foe_sign_vote_search
// Stores one frame of flow points and finds the focus of expansion by
// counting sign disagreements over a grid of candidate columns and rows.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Beat
// item      in         start high, busy low       t_item
// result    out        o_done strobe, one cycle   t_result
// config    in         APB write, pready high     grid_step, image_width/height
//
// A point without the last mark is stored while the memory has room, and busy stays low.
// A closing item runs the search: each candidate costs one pass over the
// point memory through a single compare and counter, first for the
// columns and then for the rows.
// An empty frame gives its result in the cycle after the closing item.
// Reset is synchronous and clears the control state and registers, not the result
// register; the point memory needs no clearing. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module foe_sign_vote_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  fsvs_pkg::t_item                    i_item,
    output logic                               o_done,
    output fsvs_pkg::t_result                  o_result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fsvs_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_NEXT  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_CMP   = 6'b100000
    } t_state;

    fsvs_pkg::t_entry                   r_mem [fsvs_pkg::MAX_POINTS];
    fsvs_pkg::t_entry                   r_rd_data;

    t_state                             r_state, n_state;
    logic                               r_axis, n_axis;
    logic [fsvs_pkg::CAND_W-1:0]        r_cand, n_cand;
    logic [fsvs_pkg::CNT_W-1:0]         r_best_err, n_best_err;
    logic [fsvs_pkg::BOUND_W-1:0]       r_best_col, n_best_col;
    logic [fsvs_pkg::CNT_W-1:0]         r_err, n_err;
    logic [fsvs_pkg::ADDR_W-1:0]        r_rd_idx, n_rd_idx;
    logic                               r_rd_vld, n_rd_vld;
    logic [fsvs_pkg::CNT_W-1:0]         r_count, n_count;
    logic [fsvs_pkg::COORD_W-1:0]       r_fx, n_fx;
    logic                               r_done, n_done;
    fsvs_pkg::t_result                  r_result, n_result;
    logic [fsvs_pkg::STEP_W-1:0]        r_grid_step;
    logic [fsvs_pkg::BOUND_W-1:0]       r_width;
    logic [fsvs_pkg::BOUND_W-1:0]       r_height;

    logic                               accept;
    logic                               store;
    logic                               cfg_wr;
    logic [fsvs_pkg::STEP_W-1:0]        step_eff;
    logic [fsvs_pkg::BOUND_W-1:0]       bound;
    logic [fsvs_pkg::COORD_W-1:0]       pos;
    logic                               nonneg;
    logic                               disagree;
    logic [fsvs_pkg::COORD_W-1:0]       best_sat;
    logic [fsvs_pkg::ADDR_W-1:0]        last_idx;
    logic [fsvs_pkg::CNT_W-1:0]         count_dec;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign store    = accept && i_item.has_point
                      && (r_count < fsvs_pkg::CNT_W'(fsvs_pkg::MAX_POINTS));
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign step_eff = (r_grid_step == '0) ? fsvs_pkg::STEP_W'(1) : r_grid_step;
    assign bound    = r_axis ? r_height : r_width;
    assign pos      = r_axis ? r_rd_data.y : r_rd_data.x;
    assign nonneg   = r_axis ? r_rd_data.sy : r_rd_data.sx;
    assign disagree = (({2'b00, pos} <= r_cand) == nonneg);
    assign best_sat = (r_best_col > fsvs_pkg::BOUND_W'(fsvs_pkg::COORD_MAX))
                      ? fsvs_pkg::COORD_MAX : r_best_col[fsvs_pkg::COORD_W-1:0];
    assign count_dec = r_count - fsvs_pkg::CNT_W'(1);
    assign last_idx  = count_dec[fsvs_pkg::ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mem[r_count[fsvs_pkg::ADDR_W-1:0]] <= '{x: i_item.point_x,
                                                      y: i_item.point_y,
                                                      sx: i_item.flow_x_nonneg,
                                                      sy: i_item.flow_y_nonneg};
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_cand     = r_cand;
        n_best_err = r_best_err;
        n_best_col = r_best_col;
        n_err      = r_err;
        n_rd_idx   = r_rd_idx;
        n_rd_vld   = (r_state == S_SCAN);
        n_count    = r_count;
        n_fx       = r_fx;
        n_done     = 1'b0;
        n_result   = r_result;

        if (r_rd_vld && disagree) begin
            n_err = r_err + fsvs_pkg::CNT_W'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (store) begin
                    n_count = r_count + fsvs_pkg::CNT_W'(1);
                end
                if (accept && i_item.last_point) begin
                    if ((r_count == '0) && !i_item.has_point) begin
                        n_done   = 1'b1;
                        n_result = '{foe_x: '0, foe_y: '0, found: 1'b0};
                    end else begin
                        n_axis  = 1'b0;
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_cand     = '0;
                n_best_err = '1;
                n_best_col = '0;
                n_state    = S_NEXT;
            end
            S_NEXT: begin
                if (r_cand < {1'b0, bound}) begin
                    n_err    = '0;
                    n_rd_idx = '0;
                    n_state  = S_SCAN;
                end else if (!r_axis) begin
                    n_fx    = best_sat;
                    n_axis  = 1'b1;
                    n_state = S_START;
                end else begin
                    n_done   = 1'b1;
                    n_result = '{foe_x: r_fx, foe_y: best_sat, found: 1'b1};
                    n_count  = '0;
                    n_state  = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_rd_idx == last_idx) begin
                    n_state = S_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + fsvs_pkg::ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_err < r_best_err) begin
                    n_best_err = r_err;
                    n_best_col = r_cand[fsvs_pkg::BOUND_W-1:0];
                end
                n_cand  = r_cand + fsvs_pkg::CAND_W'(step_eff);
                n_state = S_NEXT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_cand      <= '0;
            r_best_err  <= '1;
            r_best_col  <= '0;
            r_err       <= '0;
            r_rd_idx    <= '0;
            r_rd_vld    <= 1'b0;
            r_count     <= '0;
            r_fx        <= '0;
            r_done      <= 1'b0;
            r_grid_step <= fsvs_pkg::GRID_STEP_RST;
            r_width     <= fsvs_pkg::IMAGE_WIDTH_RST;
            r_height    <= fsvs_pkg::IMAGE_HEIGHT_RST;
        end else begin
            r_state    <= n_state;
            r_axis     <= n_axis;
            r_cand     <= n_cand;
            r_best_err <= n_best_err;
            r_best_col <= n_best_col;
            r_err      <= n_err;
            r_rd_idx   <= n_rd_idx;
            r_rd_vld   <= n_rd_vld;
            r_count    <= n_count;
            r_fx       <= n_fx;
            r_done     <= n_done;
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    fsvs_pkg::REG_GRID_STEP:    r_grid_step <= pwdata[fsvs_pkg::STEP_W-1:0];
                    fsvs_pkg::REG_IMAGE_WIDTH:  r_width     <= pwdata[fsvs_pkg::BOUND_W-1:0];
                    fsvs_pkg::REG_IMAGE_HEIGHT: r_height    <= pwdata[fsvs_pkg::BOUND_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    always_comb begin
        unique case (paddr[3:2])
            fsvs_pkg::REG_GRID_STEP:    prdata = 32'(r_grid_step);
            fsvs_pkg::REG_IMAGE_WIDTH:  prdata = 32'(r_width);
            fsvs_pkg::REG_IMAGE_HEIGHT: prdata = 32'(r_height);
            default:                    prdata = '0;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.found |-> (o_result.foe_x == '0) && (o_result.foe_y == '0))
        else $error("empty frame result carries a nonzero focus");

    a_store_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_count == '0))
        else $error("point store not emptied with the result beat");

    a_plain_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_item.last_point |=> !busy && !o_done)
        else $error("a point without the last mark started a search");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> (r_count != '0) && ({1'b0, r_rd_idx} < r_count))
        else $error("point memory read beyond the stored points");

endmodule

// File: sim/tb_foe_sign_vote_search.sv
// ----------------------------------------------------------------------------
// tb_foe_sign_vote_search
// Self-checking bench for the focus-of-expansion sign vote search. A short
// table of frames and register writes covers empty frames, extreme points,
// a zero grid step, a zero image bound and saturated candidates. Randomised
// phases follow, each under its register setting and one of three sender gap
// rates, with mostly consistent flow fields, noisy frames and one over-full frame.
// Every result beat is compared with a pinned value from the table or with a behavioural search run in the bench.
// ----------------------------------------------------------------------------
module tb_foe_sign_vote_search;
    timeunit 1ns;
    timeprecision 1ps;

    import fsvs_pkg::*;

    localparam int ITEM_W          = $bits(t_item);
    localparam int N_ROWS          = 21;
    localparam int N_PHASES        = 10;
    localparam int FULL_PHASE      = 2;
    localparam int BEATS_PER_PHASE = 60;
    localparam int QUIET_CYCLES    = 8;

    typedef enum logic {ROW_BEAT, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_item       item;
        logic [1:0]  reg_idx;
        int unsigned value;
        bit          pinned;
        t_result     want;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_item               i_item;
    logic                o_done;
    t_result             o_result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    logic [STEP_W-1:0]   grid_step_q = GRID_STEP_RST;
    logic [BOUND_W-1:0]  width_q     = IMAGE_WIDTH_RST;
    logic [BOUND_W-1:0]  height_q    = IMAGE_HEIGHT_RST;
    t_entry              frame_pts [MAX_POINTS];
    int unsigned         n_stored    = 0;

    t_result             pending_foes [$];
    t_result             want_foe;
    int                  n_errors    = 0;
    int                  n_beats     = 0;
    int                  idle_pct    = 0;

    foe_sign_vote_search dut (.*);

    function automatic t_item beat(input int unsigned has, input int unsigned x,
                                   input int unsigned y, input int unsigned sx,
                                   input int unsigned sy, input int unsigned last);
        return '{1'(has), COORD_W'(x), COORD_W'(y), 1'(sx), 1'(sy), 1'(last)};
    endfunction

    function automatic t_row item_row(input t_item it, input int unsigned pinned,
                                      input t_result want);
        return '{ROW_BEAT, it, REG_GRID_STEP, 0, 1'(pinned), want};
    endfunction

    function automatic t_row reg_row(input logic [1:0] idx, input int unsigned value);
        return '{ROW_REG, '0, idx, value, 1'b0, '0};
    endfunction

    t_row plan [N_ROWS] = '{
        item_row(beat(0,    0,    0, 0, 0, 1), 1, '{12'd0,    12'd0,    1'b0}),
        item_row(beat(0, 4095, 4095, 1, 1, 0), 0, '0),
        item_row(beat(1,    0,    0, 1, 1, 1), 1, '{12'd0,    12'd0,    1'b1}),
        item_row(beat(1,  100,  100, 0, 0, 1), 1, '{12'd112,  12'd112,  1'b1}),
        item_row(beat(1, 4095, 4095, 1, 1, 0), 0, '0),
        item_row(beat(1, 2048,    1, 0, 1, 0), 0, '0),
        item_row(beat(1, 1365, 2730, 1, 0, 0), 0, '0),
        item_row(beat(0,    0,    0, 0, 0, 1), 0, '0),
        reg_row(REG_GRID_STEP, 0),
        reg_row(REG_IMAGE_WIDTH, 0),
        reg_row(REG_IMAGE_HEIGHT, 5),
        item_row(beat(1,    3,    2, 1, 0, 1), 1, '{12'd0,    12'd2,    1'b1}),
        reg_row(REG_GRID_STEP, 255),
        reg_row(REG_IMAGE_WIDTH, 8191),
        reg_row(REG_IMAGE_HEIGHT, 8191),
        item_row(beat(1, 4095, 4000, 0, 0, 1), 1, '{12'd4095, 12'd4080, 1'b1}),
        item_row(beat(1,    0, 4095, 1, 0, 1), 1, '{12'd0,    12'd4095, 1'b1}),
        reg_row(REG_GRID_STEP, 1),
        reg_row(REG_IMAGE_WIDTH, 4096),
        reg_row(REG_IMAGE_HEIGHT, 1),
        item_row(beat(1, 4095,    7, 0, 1, 1), 1, '{12'd4095, 12'd0,    1'b1})
    };

    function automatic logic [COORD_W-1:0] best_cut(input bit rows, input int unsigned bound);
        int unsigned        stride;
        int unsigned        cand;
        int unsigned        errs;
        int unsigned        best_errs;
        int unsigned        best_cand;
        logic [COORD_W-1:0] pos;
        logic               nonneg;
        stride    = (grid_step_q == 0) ? 1 : grid_step_q;
        best_errs = 32'hFFFF_FFFF;
        best_cand = 0;
        for (cand = 0; cand < bound; cand += stride) begin
            errs = 0;
            for (int k = 0; k < n_stored; k++) begin
                pos    = rows ? frame_pts[k].y  : frame_pts[k].x;
                nonneg = rows ? frame_pts[k].sy : frame_pts[k].sx;
                if ((pos <= cand) == nonneg) begin
                    errs++;
                end
            end
            if (errs < best_errs) begin
                best_errs = errs;
                best_cand = cand;
            end
        end
        return (best_cand > COORD_MAX) ? COORD_MAX : best_cand[COORD_W-1:0];
    endfunction

    function automatic bit take_item(input t_item it, output t_result foe);
        foe = '0;
        if (it.has_point && n_stored < MAX_POINTS) begin
            frame_pts[n_stored] = '{it.point_x, it.point_y, it.flow_x_nonneg,
                                    it.flow_y_nonneg};
            n_stored++;
        end
        if (!it.last_point) begin
            return 1'b0;
        end
        if (n_stored != 0) begin
            foe.foe_x = best_cut(1'b0, width_q);
            foe.foe_y = best_cut(1'b1, height_q);
            foe.found = 1'b1;
        end
        n_stored = 0;
        return 1'b1;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned bound,
                                                      input int unsigned stride);
        int unsigned v;
        case ($urandom_range(2))
            0: begin
                v = $urandom_range(0, 4095);
            end
            1: begin
                v = (bound == 0) ? 0 : $urandom_range(0, bound - 1);
            end
            default: begin
                v = stride * $urandom_range(0, 64) + $urandom_range(0, 1);
            end
        endcase
        return (v > COORD_MAX) ? COORD_MAX : COORD_W'(v);
    endfunction

    function automatic int unsigned pick_bound();
        case ($urandom_range(3))
            0:       return $urandom_range(0, 8191);
            1:       return $urandom_range(1, 300);
            2:       return 4096;
            default: return $urandom_range(0, 1);
        endcase
    endfunction

    task automatic drive_beat(input t_item it, input bit pinned, input t_result pin_foe);
        t_result foe;
        while ($urandom_range(99) < idle_pct) begin
            start  <= 1'b0;
            i_item <= ITEM_W'($urandom);
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        if (it.has_point || it.last_point) begin
            n_beats++;
        end
        if (take_item(it, foe)) begin
            pending_foes.insert(pending_foes.size(), pinned ? pin_foe : foe);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_foes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        logic [31:0] kept;
        case (idx)
            REG_GRID_STEP: begin
                grid_step_q = value[STEP_W-1:0];
                kept        = 32'(grid_step_q);
            end
            REG_IMAGE_WIDTH: begin
                width_q = value[BOUND_W-1:0];
                kept    = 32'(width_q);
            end
            default: begin
                height_q = value[BOUND_W-1:0];
                kept     = 32'(height_q);
            end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== kept) begin
            $error("prdata: expected %0d, got %0d", kept, prdata);
            n_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_frame(input int n_items, input bit tidy);
        t_item       it;
        int unsigned fx;
        int unsigned fy;
        int unsigned stride;
        stride = (grid_step_q == 0) ? 1 : grid_step_q;
        fx     = $urandom_range(0, width_q);
        fy     = $urandom_range(0, height_q);
        for (int i = 0; i < n_items; i++) begin
            it.point_x    = pick_coord(width_q, stride);
            it.point_y    = pick_coord(height_q, stride);
            it.last_point = (i == n_items - 1);
            if (tidy) begin
                it.has_point     = !(it.last_point && $urandom_range(3) == 0);
                it.flow_x_nonneg = (it.point_x > fx) ^ ($urandom_range(9) == 0);
                it.flow_y_nonneg = (it.point_y > fy) ^ ($urandom_range(9) == 0);
            end else begin
                it.has_point     = ($urandom_range(3) != 0);
                it.flow_x_nonneg = 1'($urandom_range(1));
                it.flow_y_nonneg = 1'($urandom_range(1));
            end
            drive_beat(it, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done !== 1'b0) begin
            if (pending_foes.size() == 0) begin
                $error("o_done: result beat with none expected, foe_x %0d foe_y %0d",
                       o_result.foe_x, o_result.foe_y);
                n_errors++;
            end else begin
                want_foe = pending_foes.pop_front();
                if (o_result.foe_x !== want_foe.foe_x) begin
                    $error("foe_x: expected %0d, got %0d", want_foe.foe_x, o_result.foe_x);
                    n_errors++;
                end
                if (o_result.foe_y !== want_foe.foe_y) begin
                    $error("foe_y: expected %0d, got %0d", want_foe.foe_y, o_result.foe_y);
                    n_errors++;
                end
                if (o_result.found !== want_foe.found) begin
                    $error("found: expected %0d, got %0d", want_foe.found, o_result.found);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("tb_foe_sign_vote_search: FAIL");
        $finish;
    end

    initial begin
        int unsigned step;
        int unsigned w;
        int unsigned h;
        int unsigned lo;
        int          first;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (plan[r].kind == ROW_REG) begin
                if (r == 0 || plan[r-1].kind == ROW_BEAT) begin
                    settle();
                end
                write_reg(plan[r].reg_idx, plan[r].value);
            end else begin
                drive_beat(plan[r].item, plan[r].pinned, plan[r].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    step = 1;
                    w    = 64;
                    h    = 64;
                end
                1: begin
                    step = 255;
                    w    = 8191;
                    h    = 8191;
                end
                FULL_PHASE: begin
                    step = 64;
                    w    = 256;
                    h    = 256;
                end
                3: begin
                    step = 0;
                    w    = 40;
                    h    = 1;
                end
                4: begin
                    step = $urandom_range(64, 255);
                    w    = 4096;
                    h    = 4096;
                end
                default: begin
                    w    = pick_bound();
                    h    = pick_bound();
                    lo   = ((w > h ? w : h) + 63) / 64;
                    step = $urandom_range((lo <= 1) ? 0 : lo, 255);
                end
            endcase
            settle();
            write_reg(REG_GRID_STEP, step);
            write_reg(REG_IMAGE_WIDTH, w);
            write_reg(REG_IMAGE_HEIGHT, h);
            idle_pct = (ph % 4 == 1) ? 55 : (ph % 4 == 3) ? 20 : 0;
            first    = n_beats;
            if (ph == FULL_PHASE) begin
                run_frame(MAX_POINTS + 6, 1'b1);
            end
            while (n_beats - first < BEATS_PER_PHASE) begin
                run_frame($urandom_range(1, 10), $urandom_range(99) < 70);
            end
        end

        settle();
        if (n_errors == 0) begin
            $display("tb_foe_sign_vote_search: PASS");
        end else begin
            $display("tb_foe_sign_vote_search: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/fsvs_pkg.sv
rtl/core/foe_sign_vote_search.sv
sim/tb_foe_sign_vote_search.sv
